// File: rtl/hold_time_button_mode_controller_macros.svh
// Assertion helpers used by the controller RTL.
`ifndef HOLD_TIME_BUTTON_MODE_CONTROLLER_MACROS_SVH
`define HOLD_TIME_BUTTON_MODE_CONTROLLER_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define HTBMC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HTBMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define HTBMC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/htbmc_pkg.sv
package htbmc_pkg;

    // Action codes reported per item
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_STEP    = 3'd1,
        ACT_SERIES  = 3'd2,
        ACT_ADDED   = 3'd3,
        ACT_TOGGLED = 3'd4,
        ACT_CLEARED = 3'd5
    } t_action;

    // Indicator codes
    localparam logic [1:0] IND_NORMAL = 2'd0;
    localparam logic [1:0] IND_ADD    = 2'd1;
    localparam logic [1:0] IND_TOGGLE = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_STEP_HOLD   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SERIES_HOLD = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ADD_HOLD    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_TOGGLE_HOLD = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_CLEAR_HOLD  = 3'd4;

    // Field widths
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned MODE_W   = 4;
    localparam int unsigned SERIES_W = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned IN_TW    = 8;
    localparam int unsigned OUT_TW   = 24;

    // Threshold reset values
    localparam logic [HOLD_W-1:0] STEP_HOLD_RST   = 16'd14;
    localparam logic [HOLD_W-1:0] SERIES_HOLD_RST = 16'd700;
    localparam logic [HOLD_W-1:0] ADD_HOLD_RST    = 16'd3000;
    localparam logic [HOLD_W-1:0] TOGGLE_HOLD_RST = 16'd10000;
    localparam logic [HOLD_W-1:0] CLEAR_HOLD_RST  = 16'd18000;

    localparam logic [MODE_W-1:0]   MODE_FIRST   = 4'd1;
    localparam logic [MODE_W-1:0]   MODE_DARK    = 4'd0;
    localparam logic [SERIES_W-1:0] SERIES_ONE   = 2'd1;
    localparam logic [SERIES_W-1:0] SERIES_TWO   = 2'd2;

    // Favorites store access issued by the controller
    typedef struct packed {
        logic                we;
        logic                re;
        logic [MODE_W-1:0]   mode;
        logic [SERIES_W-1:0] series;
    } t_fav_req;

    // Registered view of the state after the last item
    typedef struct packed {
        t_action             action;
        logic [1:0]          indicator;
        logic [MODE_W-1:0]   mode;
        logic [SERIES_W-1:0] series;
        logic                play;
        logic                count_nz;
    } t_view;

endpackage

// File: rtl/htbmc_fav_store.sv
module htbmc_fav_store #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                               i_clk,
    input  htbmc_pkg::t_fav_req                i_req,
    input  logic [AW-1:0]                      i_waddr,
    input  logic [AW-1:0]                      i_raddr,
    output logic [htbmc_pkg::MODE_W-1:0]       o_rd_mode,
    output logic [htbmc_pkg::SERIES_W-1:0]     o_rd_series
);

    localparam int unsigned DW = htbmc_pkg::MODE_W + htbmc_pkg::SERIES_W;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_waddr] <= {i_req.series, i_req.mode};
        end
    end

    // Registered read, held while no item is taken
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rd_mode   = r_rd_data[htbmc_pkg::MODE_W-1:0];
    assign o_rd_series = r_rd_data[DW-1:htbmc_pkg::MODE_W];

endmodule

// File: rtl/htbmc_ctrl.sv
`include "hold_time_button_mode_controller_macros.svh"

module htbmc_ctrl #(
    parameter int unsigned FAV_DEPTH  = 16,
    parameter int unsigned MODE_COUNT = 9,
    parameter int unsigned AW         = 4,
    parameter int unsigned CW         = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config
    input  logic                              i_cfg_we,
    input  logic [htbmc_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [htbmc_pkg::HOLD_W-1:0]      i_cfg_wdata,
    // input handshake
    input  logic                              i_valid,
    input  logic                              i_pressed,
    output logic                              o_ready,
    // output handshake
    output logic                              o_valid,
    input  logic                              i_ready,
    output htbmc_pkg::t_view                  o_view,
    output logic [AW-1:0]                     o_index,
    // favorites store
    output htbmc_pkg::t_fav_req               o_req,
    output logic [AW-1:0]                     o_waddr,
    output logic [AW-1:0]                     o_raddr
);

    localparam int unsigned HW = htbmc_pkg::HOLD_W;
    localparam int unsigned MW = htbmc_pkg::MODE_W;
    localparam int unsigned SW = htbmc_pkg::SERIES_W;

    // threshold registers
    logic [HW-1:0] r_step_hold, r_series_hold, r_add_hold, r_toggle_hold, r_clear_hold;

    // hold state
    logic [HW-1:0] r_held, n_held;
    logic          r_was, n_was;
    logic [MW-1:0] r_mode, n_mode;
    logic [SW-1:0] r_series, n_series;
    logic          r_play, n_play;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_index, n_index;
    logic [1:0]    r_pend, n_pend;
    htbmc_pkg::t_action r_action, n_action;
    logic          r_out_valid;

    logic          accept;
    logic          wr_fav;
    logic [HW-1:0] held_inc;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Threshold writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_hold   <= htbmc_pkg::STEP_HOLD_RST;
            r_series_hold <= htbmc_pkg::SERIES_HOLD_RST;
            r_add_hold    <= htbmc_pkg::ADD_HOLD_RST;
            r_toggle_hold <= htbmc_pkg::TOGGLE_HOLD_RST;
            r_clear_hold  <= htbmc_pkg::CLEAR_HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                htbmc_pkg::CFG_STEP_HOLD:   r_step_hold   <= i_cfg_wdata;
                htbmc_pkg::CFG_SERIES_HOLD: r_series_hold <= i_cfg_wdata;
                htbmc_pkg::CFG_ADD_HOLD:    r_add_hold    <= i_cfg_wdata;
                htbmc_pkg::CFG_TOGGLE_HOLD: r_toggle_hold <= i_cfg_wdata;
                htbmc_pkg::CFG_CLEAR_HOLD:  r_clear_hold  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Hold count and classification of one item
    always_comb begin
        n_mode   = r_mode;
        n_series = r_series;
        n_play   = r_play;
        n_count  = r_count;
        n_index  = r_index;
        n_pend   = r_pend;
        n_action = htbmc_pkg::ACT_NONE;
        wr_fav   = 1'b0;
        held_inc = (i_pressed && (r_held != '1)) ? r_held + HW'(1) : r_held;

        if (i_pressed == r_was) begin
            if (held_inc > r_clear_hold) begin
                n_count  = '0;
                n_index  = '0;
                n_play   = 1'b0;
                n_pend   = htbmc_pkg::IND_NORMAL;
                n_action = htbmc_pkg::ACT_CLEARED;
            end else if (held_inc > r_toggle_hold) begin
                n_pend = htbmc_pkg::IND_TOGGLE;
                if (!i_pressed) begin
                    if (!r_play) begin
                        n_play  = 1'b1;
                        n_index = '0;
                    end else begin
                        n_play = 1'b0;
                    end
                    n_pend   = htbmc_pkg::IND_NORMAL;
                    n_action = htbmc_pkg::ACT_TOGGLED;
                end
            end else if (held_inc > r_add_hold) begin
                if (!r_play) begin
                    n_pend = htbmc_pkg::IND_ADD;
                    if (!i_pressed) begin
                        // a full list ignores the add
                        if (r_count < CW'(FAV_DEPTH)) begin
                            wr_fav  = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                        n_pend   = htbmc_pkg::IND_NORMAL;
                        n_action = htbmc_pkg::ACT_ADDED;
                    end
                end
            end else if (held_inc > r_series_hold) begin
                if (!r_play && !i_pressed) begin
                    n_series = (r_series == htbmc_pkg::SERIES_ONE) ?
                               htbmc_pkg::SERIES_TWO : htbmc_pkg::SERIES_ONE;
                    n_mode   = htbmc_pkg::MODE_FIRST;
                    n_action = htbmc_pkg::ACT_SERIES;
                end
            end else if (held_inc > r_step_hold) begin
                if (!i_pressed) begin
                    if (!r_play) begin
                        n_mode = (r_mode >= MW'(MODE_COUNT)) ?
                                 htbmc_pkg::MODE_FIRST : r_mode + MW'(1);
                    end else begin
                        n_index = ((CW'(r_index) + CW'(1)) >= r_count) ?
                                  '0 : r_index + AW'(1);
                    end
                    n_action = htbmc_pkg::ACT_STEP;
                end
            end
        end

        // two released items in a row end the hold
        n_held = (!i_pressed && !r_was) ? '0 : held_inc;
        n_was  = i_pressed;
    end

    // State update on each taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_was       <= 1'b0;
            r_mode      <= htbmc_pkg::MODE_FIRST;
            r_series    <= htbmc_pkg::SERIES_ONE;
            r_play      <= 1'b0;
            r_count     <= '0;
            r_index     <= '0;
            r_pend      <= htbmc_pkg::IND_NORMAL;
            r_action    <= htbmc_pkg::ACT_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_held   <= n_held;
                r_was    <= n_was;
                r_mode   <= n_mode;
                r_series <= n_series;
                r_play   <= n_play;
                r_count  <= n_count;
                r_index  <= n_index;
                r_pend   <= n_pend;
                r_action <= n_action;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Store access: append at the fill count, read the favorite to show
    assign o_req.we     = accept && wr_fav;
    assign o_req.re     = accept;
    assign o_req.mode   = r_mode;
    assign o_req.series = r_series;
    assign o_waddr      = r_count[AW-1:0];
    assign o_raddr      = n_index;

    assign o_valid          = r_out_valid;
    assign o_index          = r_index;
    assign o_view.action    = r_action;
    assign o_view.indicator = r_pend;
    assign o_view.mode      = r_mode;
    assign o_view.series    = r_series;
    assign o_view.play      = r_play;
    assign o_view.count_nz  = (r_count != '0);

    `HTBMC_ASSERT_ALWAYS(a_count_max, r_count <= CW'(FAV_DEPTH), "favorite count past depth")
    `HTBMC_ASSERT_ALWAYS(a_index_in_list, (CW'(r_index) < r_count) || ((r_count == '0) && (r_index == '0)), "favorite index outside list")
    `HTBMC_ASSERT_SAME(a_write_play_off, o_req.we, !r_play && accept, "store written during playback")
    `HTBMC_ASSERT_NEXT(a_clear_empties, accept && (n_action == htbmc_pkg::ACT_CLEARED), (r_count == '0) && !r_play, "clear left favorites")

endmodule

// File: rtl/hold_time_button_mode_controller.sv
// Hold-time button mode controller.
// Slave stream: one sampled button level per item (tdata bit 0, 1 = pressed).
// Master stream: one result item per input item, carrying the action, save
// request, indicator and the selection to display.
// Config port: i_cfg_we writes i_cfg_wdata to threshold i_cfg_addr
// (0 step, 1 series, 2 add, 3 toggle, 4 clear); other indexes are ignored.
// Write thresholds only while no item is in flight.
// Latency: the result of an item is valid on the cycle after it is taken.
// Throughput: one item per cycle while the receiver is ready; all hold state is registered together and
// the favorites memory is read once per item through its registered read port.
// A stalled receiver holds the result; a new item is taken in the same cycle
// the waiting result is taken, otherwise o_s_tready stays low.
// Reset: thresholds return to 14/700/3000/10000/18000, mode and series to 1,
// favorites list empty, playback off. The memory needs no clearing pass.

module hold_time_button_mode_controller #(
    parameter int unsigned FAV_DEPTH  = 16,
    parameter int unsigned MODE_COUNT = 9
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [htbmc_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [htbmc_pkg::HOLD_W-1:0]         i_cfg_wdata,
    // input stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [htbmc_pkg::IN_TW-1:0]          i_s_tdata,  // [0] button_pressed
    // output stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [2:0] action, [3] save_request, [5:4] indicator, [9:6] shown_mode,
    // [11:10] shown_series, [12] favorites_on, [16:13] favorite_slot
    output logic [htbmc_pkg::OUT_TW-1:0]         o_m_tdata
);

    localparam int unsigned FAV_AW = (FAV_DEPTH > 1) ? $clog2(FAV_DEPTH) : 1;
    localparam int unsigned FAV_CW = $clog2(FAV_DEPTH + 1);

    htbmc_pkg::t_fav_req                 fav_req;
    htbmc_pkg::t_view                    view;
    logic [FAV_AW-1:0]                   fav_waddr;
    logic [FAV_AW-1:0]                   fav_raddr;
    logic [FAV_AW-1:0]                   fav_index;
    logic [htbmc_pkg::MODE_W-1:0]        rd_mode;
    logic [htbmc_pkg::SERIES_W-1:0]      rd_series;
    logic [htbmc_pkg::MODE_W-1:0]        shown_mode;
    logic [htbmc_pkg::SERIES_W-1:0]      shown_series;

    htbmc_ctrl #(
        .FAV_DEPTH  (FAV_DEPTH),
        .MODE_COUNT (MODE_COUNT),
        .AW         (FAV_AW),
        .CW         (FAV_CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .i_pressed   (i_s_tdata[0]),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_view      (view),
        .o_index     (fav_index),
        .o_req       (fav_req),
        .o_waddr     (fav_waddr),
        .o_raddr     (fav_raddr)
    );

    htbmc_fav_store #(
        .DEPTH (FAV_DEPTH),
        .AW    (FAV_AW)
    ) u_fav_store (
        .i_clk       (i_clk),
        .i_req       (fav_req),
        .i_waddr     (fav_waddr),
        .i_raddr     (fav_raddr),
        .o_rd_mode   (rd_mode),
        .o_rd_series (rd_series)
    );

    // Displayed selection: current one, stored favorite, or dark on empty list
    always_comb begin
        if (!view.play) begin
            shown_mode   = view.mode;
            shown_series = view.series;
        end else if (view.count_nz) begin
            shown_mode   = rd_mode;
            shown_series = rd_series;
        end else begin
            shown_mode   = htbmc_pkg::MODE_DARK;
            shown_series = htbmc_pkg::SERIES_ONE;
        end
    end

    assign o_m_tdata = {
        7'd0,
        htbmc_pkg::SLOT_W'(fav_index),
        view.play,
        shown_series,
        shown_mode,
        view.indicator,
        (view.action != htbmc_pkg::ACT_NONE),
        view.action
    };

endmodule

// File: tb/sv/hold_time_button_mode_controller_tb.sv
`timescale 1ns / 1ps

module hold_time_button_mode_controller_tb;

    localparam int unsigned FAV_SLOTS   = 16;
    localparam int unsigned MODE_LAST   = 9;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_SLACK = 4;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned LIM_W       = htbmc_pkg::HOLD_W;

    // One result item as seen on the master stream
    typedef struct packed {
        htbmc_pkg::t_action                action;
        logic                              save;
        logic [1:0]                        indicator;
        logic [htbmc_pkg::MODE_W-1:0]      mode;
        logic [htbmc_pkg::SERIES_W-1:0]    series;
        logic                              fav_on;
        logic [htbmc_pkg::SLOT_W-1:0]      slot;
    } t_lamp_view;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [htbmc_pkg::CFG_AW-1:0]   i_cfg_addr  = '0;
    logic [htbmc_pkg::HOLD_W-1:0]   i_cfg_wdata = '0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [htbmc_pkg::IN_TW-1:0]    i_s_tdata   = '0;    // [0] button_pressed
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    // [2:0] action, [3] save_request, [5:4] indicator, [9:6] shown_mode,
    // [11:10] shown_series, [12] favorites_on, [16:13] favorite_slot
    logic [htbmc_pkg::OUT_TW-1:0]   o_m_tdata;

    // Predicted controller state
    logic [htbmc_pkg::HOLD_W-1:0]   hold_limit [0:4];
    logic [htbmc_pkg::HOLD_W-1:0]   hold_cnt     = '0;
    logic                           prev_pressed = 1'b0;
    logic [htbmc_pkg::MODE_W-1:0]   cur_mode     = htbmc_pkg::MODE_FIRST;
    logic [htbmc_pkg::SERIES_W-1:0] cur_series   = htbmc_pkg::SERIES_ONE;
    logic                           play_on      = 1'b0;
    logic [4:0]                     fav_cnt      = '0;
    logic [htbmc_pkg::SLOT_W-1:0]   fav_idx      = '0;
    logic [htbmc_pkg::MODE_W-1:0]   fav_modes [FAV_SLOTS];
    logic [htbmc_pkg::SERIES_W-1:0] fav_series [FAV_SLOTS];
    logic [1:0]                     ind_q        = htbmc_pkg::IND_NORMAL;

    t_lamp_view  lamp_views_due [$];
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned fail_count     = 0;
    int unsigned stall_cycles   = 0;
    int unsigned sink_hold_left = 0;
    bit          src_idle_on    = 1'b0;
    bit          sink_idle_on   = 1'b0;
    bit          took_in;
    bit          took_out;

    hold_time_button_mode_controller #(
        .FAV_DEPTH  (FAV_SLOTS),
        .MODE_COUNT (MODE_LAST)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        hold_limit[htbmc_pkg::CFG_STEP_HOLD]   = htbmc_pkg::STEP_HOLD_RST;
        hold_limit[htbmc_pkg::CFG_SERIES_HOLD] = htbmc_pkg::SERIES_HOLD_RST;
        hold_limit[htbmc_pkg::CFG_ADD_HOLD]    = htbmc_pkg::ADD_HOLD_RST;
        hold_limit[htbmc_pkg::CFG_TOGGLE_HOLD] = htbmc_pkg::TOGGLE_HOLD_RST;
        hold_limit[htbmc_pkg::CFG_CLEAR_HOLD]  = htbmc_pkg::CLEAR_HOLD_RST;
    end

    // Advance the predicted controller by one button tick
    function automatic t_lamp_view advance_button_tick(input logic pressed);
        t_lamp_view         v;
        htbmc_pkg::t_action act;
        act = htbmc_pkg::ACT_NONE;
        if (pressed && hold_cnt != {htbmc_pkg::HOLD_W{1'b1}})
            hold_cnt = hold_cnt + 1'b1;
        // classify only when the level repeats; first passing test decides
        if (pressed == prev_pressed) begin
            if (hold_cnt > hold_limit[htbmc_pkg::CFG_CLEAR_HOLD]) begin
                fav_cnt = '0;
                fav_idx = '0;
                play_on = 1'b0;
                ind_q   = htbmc_pkg::IND_NORMAL;
                act     = htbmc_pkg::ACT_CLEARED;
            end else if (hold_cnt > hold_limit[htbmc_pkg::CFG_TOGGLE_HOLD]) begin
                ind_q = htbmc_pkg::IND_TOGGLE;
                if (!pressed) begin
                    if (!play_on) begin
                        play_on = 1'b1;
                        fav_idx = '0;
                    end else begin
                        play_on = 1'b0;
                    end
                    ind_q = htbmc_pkg::IND_NORMAL;
                    act   = htbmc_pkg::ACT_TOGGLED;
                end
            end else if (hold_cnt > hold_limit[htbmc_pkg::CFG_ADD_HOLD]) begin
                if (!play_on) begin
                    ind_q = htbmc_pkg::IND_ADD;
                    if (!pressed) begin
                        // full list: no entry written, still reported
                        if (fav_cnt < FAV_SLOTS) begin
                            fav_modes[fav_cnt[3:0]]  = cur_mode;
                            fav_series[fav_cnt[3:0]] = cur_series;
                            fav_cnt = fav_cnt + 1'b1;
                        end
                        ind_q = htbmc_pkg::IND_NORMAL;
                        act   = htbmc_pkg::ACT_ADDED;
                    end
                end
            end else if (hold_cnt > hold_limit[htbmc_pkg::CFG_SERIES_HOLD]) begin
                if (!play_on && !pressed) begin
                    cur_series = (cur_series == htbmc_pkg::SERIES_ONE) ?
                                 htbmc_pkg::SERIES_TWO : htbmc_pkg::SERIES_ONE;
                    cur_mode   = htbmc_pkg::MODE_FIRST;
                    act        = htbmc_pkg::ACT_SERIES;
                end
            end else if (hold_cnt > hold_limit[htbmc_pkg::CFG_STEP_HOLD]) begin
                if (!pressed) begin
                    if (!play_on)
                        cur_mode = (cur_mode >= MODE_LAST) ?
                                   htbmc_pkg::MODE_FIRST : cur_mode + 1'b1;
                    else
                        fav_idx = ({1'b0, fav_idx} + 5'd1 >= fav_cnt) ? '0 : fav_idx + 1'b1;
                    act = htbmc_pkg::ACT_STEP;
                end
            end
        end
        if (!pressed && !prev_pressed)
            hold_cnt = '0;
        prev_pressed = pressed;

        v.action    = act;
        v.save      = (act != htbmc_pkg::ACT_NONE);
        v.indicator = ind_q;
        v.fav_on    = play_on;
        v.slot      = fav_idx;
        if (!play_on) begin
            v.mode   = cur_mode;
            v.series = cur_series;
        end else if (fav_cnt != 0) begin
            v.mode   = fav_modes[fav_idx];
            v.series = fav_series[fav_idx];
        end else begin
            v.mode   = htbmc_pkg::MODE_DARK;
            v.series = htbmc_pkg::SERIES_ONE;
        end
        return v;
    endfunction

    // Compare one result item against the oldest prediction
    function automatic void check_lamp_result(input logic [htbmc_pkg::OUT_TW-1:0] data);
        t_lamp_view got;
        t_lamp_view want;
        got.action    = htbmc_pkg::t_action'(data[2:0]);
        got.save      = data[3];
        got.indicator = data[5:4];
        got.mode      = data[9:6];
        got.series    = data[11:10];
        got.fav_on    = data[12];
        got.slot      = data[16:13];
        if (lamp_views_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected result item %h", data);
        end else begin
            want = lamp_views_due.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display({"mismatch at result %0d: expected act=%0d save=%0d ind=%0d ",
                              "mode=%0d series=%0d fav=%0d slot=%0d, got act=%0d save=%0d ",
                              "ind=%0d mode=%0d series=%0d fav=%0d slot=%0d"},
                             results_seen, want.action, want.save, want.indicator,
                             want.mode, want.series, want.fav_on, want.slot,
                             got.action, got.save, got.indicator, got.mode,
                             got.series, got.fav_on, got.slot);
            end
        end
    endfunction

    // Handshake monitor: predict on accepted input, check accepted output
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            took_in  = i_s_tvalid && o_s_tready;
            took_out = o_m_tvalid && i_m_tready;
            if (took_in)
                lamp_views_due.push_back(advance_button_tick(i_s_tdata[0]));
            if (took_out) begin
                check_lamp_result(o_m_tdata);
                results_seen++;
            end
            if (took_in || took_out)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Receiver ready: long hold-off on request, else random stalls when enabled
    always @(posedge i_clk) begin
        if (sink_hold_left > 0) begin
            i_m_tready <= 1'b0;
            sink_hold_left--;
        end else if (sink_idle_on && $urandom_range(99) < 28) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted item
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Offer one button level and wait until it is taken
    task automatic send_level(input logic level);
        if (src_idle_on && $urandom_range(99) < 28) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(htbmc_pkg::IN_TW - 1){1'b0}}, level};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic hold_button(input int unsigned pressed_ticks, input int unsigned released_ticks);
        repeat (pressed_ticks) send_level(1'b1);
        repeat (released_ticks) send_level(1'b0);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (results_seen < items_sent) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    // Write all five thresholds while the block is idle
    task automatic write_hold_limits(input logic [htbmc_pkg::HOLD_W-1:0] step_v, series_v,
                                     add_v, toggle_v, clear_v);
        logic [htbmc_pkg::HOLD_W-1:0] vals [0:4];
        vals[htbmc_pkg::CFG_STEP_HOLD]   = step_v;
        vals[htbmc_pkg::CFG_SERIES_HOLD] = series_v;
        vals[htbmc_pkg::CFG_ADD_HOLD]    = add_v;
        vals[htbmc_pkg::CFG_TOGGLE_HOLD] = toggle_v;
        vals[htbmc_pkg::CFG_CLEAR_HOLD]  = clear_v;
        wait_drained();
        for (int i = 0; i <= htbmc_pkg::CFG_CLEAR_HOLD; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= htbmc_pkg::CFG_AW'(i);
            i_cfg_wdata <= vals[i];
            hold_limit[i] = vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Step and series thresholds as they come out of reset, exact boundary included
    task automatic test_reset_limits();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_button(0, 2);
        hold_button(14, 2);
        hold_button(15, 2);
        hold_button(701, 2);
    endtask

    // Every action once with tight thresholds, low extreme included
    task automatic test_each_action();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        write_hold_limits(16'd0, 16'd1, 16'd2, 16'd3, 16'd4);
        hold_button(1, 2);      // next mode
        hold_button(2, 2);      // next series
        hold_button(3, 2);      // append
        hold_button(4, 2);      // playback on
        hold_button(1, 2);      // next favorite, wraps
        hold_button(2, 2);      // series ignored in playback
        hold_button(3, 2);      // add ignored in playback
        // single released tick inside a hold keeps the count
        hold_button(2, 1);
        hold_button(2, 2);
        hold_button(6, 2);      // clear while still held
    endtask

    // Fill the list past its depth, then play it back
    task automatic test_favorites_list();
        write_hold_limits(16'd0, 16'd1, 16'd2, 16'd3, 16'd40);
        hold_button(42, 2);
        repeat (FAV_SLOTS + 2) begin
            repeat ($urandom_range(0, 3)) hold_button(1, 2);
            if ($urandom_range(3) == 0)
                hold_button(2, 2);
            hold_button(3, 2);
        end
        hold_button(4, 2);
        repeat (FAV_SLOTS + 4) hold_button(1, 2);
        hold_button(2, 2);
        hold_button(3, 2);
        hold_button(4, 2);
        hold_button(4, 2);
        hold_button(1, 2);
        // playback with an empty list shows a dark lamp
        hold_button(42, 2);
        hold_button(4, 2);
        hold_button(1, 2);
        hold_button(4, 2);
    endtask

    // Thresholds at the top of their range: short holds trigger nothing
    task automatic test_high_limits();
        write_hold_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        hold_button(3, 2);
    endtask

    // Random holds aimed around the current thresholds, plus noise
    task automatic run_random_holds(input int unsigned budget);
        int unsigned first_item;
        int unsigned pick;
        int unsigned len;
        int unsigned split;
        first_item = items_sent;
        while (items_sent - first_item < budget) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                len = hold_limit[$urandom_range(0, htbmc_pkg::CFG_CLEAR_HOLD)] +
                      $urandom_range(0, 2);
                if (len > 80)
                    len = $urandom_range(1, 80);
                if (len == 0)
                    len = 1;
                if ($urandom_range(99) < 15) begin
                    split = $urandom_range(1, len);
                    hold_button(split, 1);
                    len = len - split;
                end
                hold_button(len, ($urandom_range(99) < 10) ? 1 : $urandom_range(2, 4));
            end else begin
                repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_random_holds();
        int unsigned s;
        int unsigned se;
        int unsigned a;
        int unsigned tg;

        // ordered, tight thresholds; long receiver hold-off in the middle
        s  = $urandom_range(0, 3);
        se = s + $urandom_range(1, 4);
        a  = se + $urandom_range(1, 4);
        tg = a + $urandom_range(1, 4);
        write_hold_limits(LIM_W'(s), LIM_W'(se), LIM_W'(a), LIM_W'(tg),
                          LIM_W'(tg + $urandom_range(1, 6)));
        run_random_holds(100);
        sink_hold_left = 400;
        run_random_holds(160);

        // misordered thresholds; sender pauses until drained
        write_hold_limits(LIM_W'($urandom_range(0, 15)), LIM_W'($urandom_range(0, 15)),
                          LIM_W'($urandom_range(0, 15)), LIM_W'($urandom_range(0, 15)),
                          LIM_W'($urandom_range(0, 15)));
        run_random_holds(100);
        wait_drained();
        repeat ($urandom_range(5, 20)) @(posedge i_clk);
        run_random_holds(90);

        // everything at zero
        write_hold_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random_holds(70);

        // ordered, wider spacing
        s  = $urandom_range(0, 10);
        se = s + $urandom_range(5, 20);
        a  = se + $urandom_range(5, 20);
        tg = a + $urandom_range(5, 20);
        write_hold_limits(LIM_W'(s), LIM_W'(se), LIM_W'(a), LIM_W'(tg),
                          LIM_W'(tg + $urandom_range(5, 20)));
        run_random_holds(180);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_limits();
        test_each_action();
        test_favorites_list();
        test_high_limits();
        test_random_holds();
        wait_drained();
        if (fail_count == 0 && lamp_views_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
